### sv/firs_pkg.sv
package firs_pkg;

  // history and coefficient store depth
  localparam int MAX_TAPS = 256;
  localparam int MaxGroups = MAX_TAPS / 4;
  localparam int AddrW = $clog2(MAX_TAPS);
  localparam int TapW = $clog2(MAX_TAPS + 1);

  // fixed Q15 scaling of the dot product
  localparam int Q15_SHIFT = 15;

  // field widths
  localparam int SampleW = 32;
  localparam int CoefW = 16;
  localparam int ProdW = SampleW + CoefW;
  localparam int AccW = 64;
  localparam int ShiftW = 6;

  // configuration port
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_TAP_GROUPS = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTPUT_SHIFT = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_INDEX = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_VALUE = 4'd3;

  // controller to datapath
  typedef struct packed {
    logic take;        // input transaction accepted
    logic write_hist;  // store the sample in the history, start the dot product
    logic issue;       // read one tap pair
    logic scale;       // shift and saturate the accumulator
    logic load_out;    // move the result into the output register
  } firs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bypass;      // tap count is zero
    logic last_tap;    // current tap is the last one
    logic pipe_empty;  // no tap pair left in the multiply pipeline
    logic out_free;    // output register can take a result this cycle
  } firs_status_t;

endpackage

### sv/firs_ctrl.sv
module firs_ctrl
  import firs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  firs_status_t status_i,
  output firs_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WRITE  = 6'b000010,
    ST_RUN    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = status_i.bypass ? ST_FINISH : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_hist = 1'b1;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (status_i.last_tap) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/firs_dp.sv
module firs_dp
  import firs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration writes
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  // sample input
  input  logic signed [SampleW-1:0]  sample_in_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  sample_out_o,
  // controller link
  input  firs_cmd_t                  cmd_i,
  output firs_status_t               status_o
);

  // configuration registers
  logic [6:0]             tap_groups_q;
  logic [4:0]             output_shift_q;
  logic [7:0]             coef_index_q;

  // memories and their valid tracking
  logic signed [SampleW-1:0] hist_mem [MAX_TAPS];
  logic signed [CoefW-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]       coef_valid_q;
  logic [TapW-1:0]           fill_q;
  logic [AddrW-1:0]          wptr_q;

  // dot product sequencing
  logic signed [SampleW-1:0] sample_q;
  logic [AddrW-1:0]          pos_q;
  logic [AddrW-1:0]          tap_q;
  logic [TapW-1:0]           tap_count;

  // multiply pipeline
  logic                      rd_v_q;
  logic                      hv_q;
  logic                      cv_q;
  logic signed [SampleW-1:0] hist_rd_q;
  logic signed [CoefW-1:0]   coef_rd_q;
  logic                      prod_v_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q;

  // result path
  logic [ShiftW-1:0]         shift_amt;
  logic signed [AccW-1:0]    shifted;
  logic signed [SampleW-1:0] sat;
  logic signed [SampleW-1:0] res_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_q;

  logic                      coef_we;
  logic [AddrW-1:0]          coef_waddr;

  // effective tap count, clamped to the store depth
  always_comb begin
    if (int'(tap_groups_q) > MaxGroups) begin
      tap_count = TapW'(MAX_TAPS);
    end else begin
      tap_count = TapW'({tap_groups_q, 2'b00});
    end
  end

  assign coef_we = cfg_we_i && (cfg_index_i == REG_COEF_VALUE) && (int'(coef_index_q) < MAX_TAPS);
  assign coef_waddr = AddrW'(coef_index_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_groups_q <= '0;
      output_shift_q <= '0;
      coef_index_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TAP_GROUPS:   tap_groups_q <= cfg_data_i[6:0];
        REG_OUTPUT_SHIFT: output_shift_q <= cfg_data_i[4:0];
        REG_COEF_INDEX:   coef_index_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // coefficient store
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= cfg_data_i;
    end
    if (cmd_i.issue) begin
      coef_rd_q <= coef_mem[tap_q];
    end
  end

  // coefficient entries written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_valid_q <= '0;
    end else if (coef_we) begin
      coef_valid_q[coef_waddr] <= 1'b1;
    end
  end

  // sample history
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_hist) begin
      hist_mem[wptr_q] <= sample_q;
    end
    if (cmd_i.issue) begin
      hist_rd_q <= hist_mem[pos_q];
    end
  end

  // write pointer and fill count, cleared by a tap count write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      fill_q <= '0;
    end else if (cfg_we_i && (cfg_index_i == REG_TAP_GROUPS)) begin
      wptr_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.write_hist) begin
      wptr_q <= (int'(wptr_q) == MAX_TAPS - 1) ? '0 : wptr_q + AddrW'(1);
      if (int'(fill_q) != MAX_TAPS) begin
        fill_q <= fill_q + TapW'(1);
      end
    end
  end

  // sample capture, read position and tap counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.write_hist) begin
      pos_q <= wptr_q;
      tap_q <= '0;
    end else if (cmd_i.issue) begin
      pos_q <= (pos_q == '0) ? AddrW'(MAX_TAPS - 1) : pos_q - AddrW'(1);
      tap_q <= tap_q + AddrW'(1);
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.issue;
      prod_v_q <= rd_v_q;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      hv_q <= TapW'(pos_q) < fill_q;
      cv_q <= coef_valid_q[tap_q];
    end
  end

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (hv_q && cv_q) begin
        prod_q <= hist_rd_q * coef_rd_q;
      end else begin
        prod_q <= '0;
      end
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_hist) begin
      acc_q <= '0;
    end else if (prod_v_q) begin
      acc_q <= acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  // scale and saturate
  assign shift_amt = ShiftW'(Q15_SHIFT) + ShiftW'(output_shift_q);
  assign shifted = acc_q >>> shift_amt;

  always_comb begin
    if ((&shifted[AccW-1:SampleW-1]) || !(|shifted[AccW-1:SampleW-1])) begin
      sat = shifted[SampleW-1:0];
    end else if (shifted[AccW-1]) begin
      sat = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  // result register, loaded directly in bypass
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (tap_groups_q == '0)) begin
      res_q <= sample_in_i;
    end else if (cmd_i.scale) begin
      res_q <= sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_out_o = out_q;

  // status to the controller
  assign status_o.bypass = (tap_groups_q == '0);
  assign status_o.last_tap = (TapW'(tap_q) + TapW'(1)) == tap_count;
  assign status_o.pipe_empty = !rd_v_q && !prod_v_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

### sv/fir_filter_32x16_saturating.sv
// channel  | direction | handshake        | payload
// ---------+-----------+------------------+-----------------------------------
// input    | in        | valid / stall    | sample_in_i  (32 bit signed)
// output   | out       | valid / stall    | sample_out_o (32 bit signed)
// config   | in        | valid / ready    | cfg_index_i, cfg_data_i
//
// one sample is processed at a time; with T = 4 * tap_groups (clamped to the
// store depth) the single multiply-accumulate unit walks an item's T taps
// one per cycle through the history and coefficient memories; bypass
// skips the taps and loads the sample straight into the result register
// the result waits in an output register, so output stall only holds the
// next item once it has finished its taps
// reset clears the configuration, the coefficient valid flags and the
// history fill count; no clearing pass runs, config writes are always ready
module fir_filter_32x16_saturating
  import firs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SampleW-1:0]  sample_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SampleW-1:0]  sample_out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  firs_cmd_t    cmd;
  firs_status_t status;

  // configuration writes are taken every cycle
  assign cfg_ready_o = 1'b1;

  // sequencing
  firs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // memories, multiply-accumulate and output register
  firs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

### tb/sv/fir_filter_checker.sv
module fir_filter_checker
  import firs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [SampleW-1:0] sample_out_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output int                        outstanding_o,
  output int                        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TapGroupsW = 7;
  localparam int OutShiftW = 5;
  localparam int CoefIdxW = 8;
  localparam logic signed [AccW-1:0] SatMax = 64'sd2147483647;
  localparam logic signed [AccW-1:0] SatMin = -64'sd2147483648;

  // shadow copy of the filter state and registers
  logic signed [SampleW-1:0] hist_mem [MAX_TAPS];
  logic [AddrW-1:0]          hist_wr_ptr;
  logic signed [CoefW-1:0]   coef_mem [MAX_TAPS];
  logic [TapGroupsW-1:0]     tap_groups_q;
  logic [OutShiftW-1:0]      out_shift_q;
  logic [CoefIdxW-1:0]       coef_index_q;

  logic signed [SampleW-1:0] expected_samples_q [$];
  logic signed [SampleW-1:0] want_sample;

  // store one sample and return the scaled, saturated dot product
  function automatic logic signed [SampleW-1:0] filter_sample(
    input logic signed [SampleW-1:0] x
  );
    int unsigned taps;
    logic [AddrW-1:0] rd_ptr;
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] scaled;
    if (tap_groups_q == 0) return x;
    taps = (tap_groups_q > MaxGroups) ? MAX_TAPS : 4 * tap_groups_q;
    hist_mem[hist_wr_ptr] = x;
    rd_ptr = hist_wr_ptr;
    hist_wr_ptr = (hist_wr_ptr == AddrW'(MAX_TAPS - 1)) ? '0 : hist_wr_ptr + 1'b1;
    acc = '0;
    // newest sample meets coefficient zero
    for (int k = 0; k < taps; k++) begin
      acc = acc + coef_mem[k] * hist_mem[rd_ptr];
      rd_ptr = (rd_ptr == '0) ? AddrW'(MAX_TAPS - 1) : rd_ptr - 1'b1;
    end
    scaled = acc >>> (Q15_SHIFT + out_shift_q);
    if (scaled > SatMax) return SatMax[SampleW-1:0];
    if (scaled < SatMin) return SatMin[SampleW-1:0];
    return scaled[SampleW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_mem[i] = '0;
        coef_mem[i] = '0;
      end
      hist_wr_ptr = '0;
      tap_groups_q = '0;
      out_shift_q = '0;
      coef_index_q = '0;
      expected_samples_q.delete();
      outstanding_o = 0;
      fail_count_o = 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TAP_GROUPS: begin
            tap_groups_q = cfg_data_i[TapGroupsW-1:0];
            for (int i = 0; i < MAX_TAPS; i++) hist_mem[i] = '0;
            hist_wr_ptr = '0;
          end
          REG_OUTPUT_SHIFT: out_shift_q = cfg_data_i[OutShiftW-1:0];
          REG_COEF_INDEX:   coef_index_q = cfg_data_i[CoefIdxW-1:0];
          REG_COEF_VALUE: begin
            if (coef_index_q < MAX_TAPS) coef_mem[coef_index_q] = cfg_data_i;
          end
          default: ;
        endcase
      end

      // output transaction against the oldest expected sample
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples_q.size() == 0) begin
          $display("%0t: unexpected sample_out, expected none, actual %0d (0x%08h)",
                   $time, sample_out_i, sample_out_i);
          fail_count_o++;
        end else begin
          want_sample = expected_samples_q.pop_front();
          if (sample_out_i !== want_sample) begin
            $display("%0t: sample_out mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, want_sample, want_sample, sample_out_i, sample_out_i);
            fail_count_o++;
          end
        end
      end

      // input transaction
      if (in_valid_i && !in_stall_i) begin
        expected_samples_q.push_back(filter_sample(sample_in_i));
      end

      outstanding_o = expected_samples_q.size();
    end
  end

endmodule

### tb/sv/tb_fir_filter_32x16_saturating.sv
module tb_fir_filter_32x16_saturating import firs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems = 1850;
  localparam int CalmItems = 150;
  localparam int HoldCycles = 500;
  localparam int EndWaitCycles = 300;
  localparam int DrainLimit = 20000;
  localparam longint TimeoutNs = 10_000_000;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 4'd15;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgDataW-1:0]       cfg_data_i;

  int outstanding;
  int fail_count;
  int items_sent;
  bit idle_en;
  bit hold_go;

  fir_filter_32x16_saturating u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  fir_filter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_out_i  (sample_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(TimeoutNs);
    $display("%0t: timeout, %0d samples still outstanding", $time, outstanding);
    $display("status: fail");
    $finish;
  end

  // one register write transaction, called at a falling edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_coef(input logic [7:0] idx, input logic [CoefW-1:0] value);
    write_reg(REG_COEF_INDEX, {8'($urandom), idx});
    write_reg(REG_COEF_VALUE, value);
  endtask

  // one input transaction, optionally preceded by an idle gap
  task automatic send_sample(input logic signed [SampleW-1:0] s);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_in_i = s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // close a burst and wait until every expected sample has come back
  task automatic finish_burst();
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // receiver: random stall bursts plus one long hold-off
  initial begin : receiver
    int stall_left;
    bit hold_used;
    stall_left = 0;
    hold_used = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        stall_left = 0;
      end
      if (stall_left > 0) stall_left--;
      else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      out_stall_i = (stall_left > 0);
    end
  end

  initial begin : stimulus
    int unsigned cur_groups;
    int unsigned eff_taps;
    int unsigned n_items;
    int unsigned n_coefs;
    int unsigned pick;
    int unsigned phase_no;
    int unsigned drain_cycles;
    logic [4:0] shift_val;
    logic [7:0] cidx;
    logic [CoefW-1:0] cval;
    logic signed [SampleW-1:0] s;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    idle_en = 1'b1;
    hold_go = 1'b0;
    items_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bypass after reset; writes to unused indexes change nothing
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    finish_burst();

    // four taps with extreme coefficients, fresh history, low saturation
    load_coef(8'd0, 16'h7FFF);
    load_coef(8'd1, 16'h8000);
    load_coef(8'd2, 16'h0001);
    load_coef(8'd3, 16'hFFFF);
    write_reg(REG_OUTPUT_SHIFT, 16'd0);
    write_reg(REG_TAP_GROUPS, 16'd1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    finish_burst();
    write_reg(REG_OUTPUT_SHIFT, 16'd31);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    finish_burst();

    // all coefficients at maximum: high and low saturation
    load_coef(8'd0, 16'h7FFF);
    load_coef(8'd1, 16'h7FFF);
    load_coef(8'd2, 16'h7FFF);
    load_coef(8'd3, 16'h7FFF);
    write_reg(REG_OUTPUT_SHIFT, 16'd0);
    write_reg(REG_TAP_GROUPS, 16'd1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    finish_burst();

    // tap count above the store depth, then exactly the store depth
    load_coef(8'd255, 16'h7FFF);
    load_coef(8'd100, 16'hFFFB);
    write_reg(REG_OUTPUT_SHIFT, 16'd3);
    write_reg(REG_TAP_GROUPS, 16'h007F);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh1234_5678);
    send_sample(32'sh8000_0000);
    finish_burst();
    write_reg(REG_TAP_GROUPS, 16'd64);
    send_sample(32'sh8000_0000);
    send_sample(32'shDEAD_BEEF);
    send_sample(32'sh7FFF_FFFF);
    finish_burst();

    // random phases, mostly short filters, a few long ones
    cur_groups = 64;
    phase_no = 0;
    while (items_sent < TotalItems) begin
      if (items_sent + CalmItems >= TotalItems) idle_en = 1'b0;

      if (phase_no == 2) begin
        cur_groups = 2;
        write_reg(REG_TAP_GROUPS, {9'($urandom), 7'(cur_groups)});
      end else if (phase_no == 0 || $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) cur_groups = 0;
        else if (pick < 80) cur_groups = $urandom_range(1, 4);
        else if (pick < 93) cur_groups = $urandom_range(5, 16);
        else cur_groups = $urandom_range(17, 127);
        write_reg(REG_TAP_GROUPS, {9'($urandom), 7'(cur_groups)});
      end

      pick = $urandom_range(0, 99);
      if (pick < 12) shift_val = 5'd0;
      else if (pick < 24) shift_val = 5'd31;
      else shift_val = 5'($urandom_range(0, 18));
      write_reg(REG_OUTPUT_SHIFT, {11'($urandom), shift_val});

      // coefficient updates, mostly within the active taps
      eff_taps = (cur_groups == 0) ? 4 : ((cur_groups > MaxGroups) ? MAX_TAPS : 4 * cur_groups);
      n_coefs = $urandom_range(0, 6);
      for (int i = 0; i < n_coefs; i++) begin
        if ($urandom_range(0, 3) == 0) cidx = 8'($urandom);
        else cidx = 8'($urandom_range(0, eff_taps - 1));
        if ($urandom_range(0, 7) == 0) cval = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else cval = 16'($urandom);
        load_coef(cidx, cval);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_COEF_VALUE, 16'($urandom));
      if ($urandom_range(0, 5) == 0) write_reg(REG_COEF_INDEX, 16'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(4'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom));
      end

      if (phase_no == 2) begin
        hold_go = 1'b1;
        n_items = 40;
      end else if (cur_groups <= 4) n_items = $urandom_range(20, 60);
      else if (cur_groups <= 16) n_items = $urandom_range(10, 30);
      else n_items = $urandom_range(2, 6);

      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: s = 32'sh7FFF_FFFF;
            1: s = 32'sh8000_0000;
            2: s = 32'sh0000_0000;
            default: s = 32'shFFFF_FFFF;
          endcase
        end else begin
          s = $urandom;
        end
        send_sample(s);
      end
      finish_burst();
      phase_no++;
    end

    // drain and settle
    drain_cycles = 0;
    while (outstanding != 0 && drain_cycles < DrainLimit) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (EndWaitCycles) @(negedge clk_i);
    if (outstanding != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, outstanding);
    end
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
